// ===== hdl/tled_pkg.sv =====
// Package for the timing event log decoder: event codes, record kinds
// and the record struct. No dependencies.
package tled_pkg;

    localparam logic [7:0] CODE_TOD_ZERO  = 8'd112;
    localparam logic [7:0] CODE_TOD_ONE   = 8'd113;
    localparam logic [7:0] CODE_HEARTBEAT = 8'd122;
    localparam logic [7:0] CODE_PPS       = 8'd125;

    localparam logic [5:0] TOD_BITS      = 6'd32;
    localparam logic [5:0] TOD_COUNT_MAX = 6'd33;

    localparam logic [2:0] KIND_HB_FIRST = 3'd0;
    localparam logic [2:0] KIND_HB       = 3'd1;
    localparam logic [2:0] KIND_PPS_SEC  = 3'd2;
    localparam logic [2:0] KIND_PPS_BARE = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [31:0] value;
    } t_rec;

endpackage

// ===== hdl/tled_decode.sv =====
// Event decoder: holds the heartbeat/event tick history and the time-of-day
// shift register, and forms up to one record per word. Depends on tled_pkg.
module tled_decode
    import tled_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic        i_op,
    input  logic [7:0]  i_code,
    input  logic [31:0] i_ticks,
    output logic        o_has_result,
    output t_rec        o_rec
);

    logic        r_first_hb;
    logic [31:0] r_last_hb_ticks;
    logic [31:0] r_last_ev_ticks;
    logic [31:0] r_time_shift;
    logic [5:0]  r_bit_count;

    logic        n_first_hb;
    logic [31:0] n_last_hb_ticks;
    logic [31:0] n_last_ev_ticks;
    logic [31:0] n_time_shift;
    logic [5:0]  n_bit_count;

    always_comb begin
        n_first_hb      = r_first_hb;
        n_last_hb_ticks = r_last_hb_ticks;
        n_last_ev_ticks = r_last_ev_ticks;
        n_time_shift    = r_time_shift;
        n_bit_count     = r_bit_count;
        o_has_result    = 1'b0;
        o_rec.kind      = KIND_OTHER;
        o_rec.code      = i_code;
        o_rec.value     = 32'd0;
        if (i_op) begin
            n_first_hb  = 1'b1;
            n_bit_count = 6'd0;
        end else if (i_code == CODE_TOD_ZERO || i_code == CODE_TOD_ONE) begin
            n_time_shift = {r_time_shift[30:0], (i_code == CODE_TOD_ONE)};
            if (r_bit_count < TOD_COUNT_MAX) begin
                n_bit_count = r_bit_count + 6'd1;
            end
        end else if (i_code == CODE_HEARTBEAT) begin
            o_has_result = 1'b1;
            if (r_first_hb) begin
                o_rec.kind = KIND_HB_FIRST;
                n_first_hb = 1'b0;
            end else begin
                o_rec.kind  = KIND_HB;
                o_rec.value = i_ticks - r_last_hb_ticks;
            end
            n_last_hb_ticks = i_ticks;
        end else if (i_code == CODE_PPS) begin
            o_has_result = 1'b1;
            if (r_bit_count == TOD_BITS) begin
                o_rec.kind  = KIND_PPS_SEC;
                o_rec.value = r_time_shift;
            end else begin
                o_rec.kind = KIND_PPS_BARE;
            end
            n_bit_count = 6'd0;
        end else begin
            o_has_result    = 1'b1;
            o_rec.value     = i_ticks - r_last_ev_ticks;
            n_last_ev_ticks = i_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_hb      <= 1'b1;
            r_last_hb_ticks <= 32'd0;
            r_last_ev_ticks <= 32'd0;
            r_time_shift    <= 32'd0;
            r_bit_count     <= 6'd0;
        end else if (i_fire) begin
            r_first_hb      <= n_first_hb;
            r_last_hb_ticks <= n_last_hb_ticks;
            r_last_ev_ticks <= n_last_ev_ticks;
            r_time_shift    <= n_time_shift;
            r_bit_count     <= n_bit_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= TOD_COUNT_MAX)
        else $error("time bit count above saturation");
    a_pps_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_op && i_code == CODE_PPS) |=> r_bit_count == 6'd0)
        else $error("pps did not clear bit count");
    a_hb_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_op && i_code == CODE_HEARTBEAT) |=> !r_first_hb)
        else $error("heartbeat left first flag set");
`endif

endmodule

// ===== hdl/timing_event_log_decoder_core.sv =====
// A word is held in the input register, its record in the output register.
// Throughput: one word per cycle unless a record stalls at the output; the
// input register drains while a record waits whenever a word yields none.
// Reset (i_rst_n low, synchronous) empties both registers and restores the
// decoder state: first-heartbeat armed, tick history, shift and count zero.
module timing_event_log_decoder_core
    import tled_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] event_code, [39:8] tick_count
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] event_code_out, [39:8] value
    output logic [2:0]  m_axis_tuser    // [2:0] record_kind
);

    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_code;
    logic [31:0] r_in_ticks;
    logic        r_out_valid;
    t_rec        r_out_rec;

    logic        has_result;
    t_rec        rec;
    logic        advance;

    assign advance = r_in_valid && (!has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    tled_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_op         (r_in_op),
        .i_code       (r_in_code),
        .i_ticks      (r_in_ticks),
        .o_has_result (has_result),
        .o_rec        (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_code  <= s_axis_tdata[7:0];
            r_in_ticks <= s_axis_tdata[39:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out_rec <= rec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_rec.value, r_out_rec.code};
    assign m_axis_tuser  = r_out_rec.kind;

`ifndef ASSERT_OFF
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_rec.kind <= KIND_OTHER)
        else $error("record kind out of range");
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rec.kind == KIND_HB_FIRST
                         || r_out_rec.kind == KIND_PPS_BARE))
        |-> r_out_rec.value == 32'd0)
        else $error("bare record carries a value");
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rec.kind == KIND_PPS_SEC
                         || r_out_rec.kind == KIND_PPS_BARE))
        |-> r_out_rec.code == CODE_PPS)
        else $error("pps record with wrong code");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && has_result && r_out_valid) |-> m_axis_tready)
        else $error("record overwritten while stalled");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timing_event_log_decoder_core: directed words, then
// time-of-day frames and noise, with records checked by an in-bench decoder.
// Depends on tled_pkg and the core only.
module testbench;
    import tled_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [7:0] event_code, [39:8] tick_count
    logic        s_axis_tuser = 1'b0; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [7:0] event_code_out, [39:8] value
    logic [2:0]  m_axis_tuser;        // [2:0] record_kind

    localparam logic OP_EVENT   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    timing_event_log_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // decoder shadow state
    logic        hb_armed = 1'b1;
    logic [31:0] hb_prev_ticks = '0;
    logic [31:0] ev_prev_ticks = '0;
    logic [31:0] tod_shift = '0;
    logic [5:0]  tod_count = '0;

    t_rec        pending_records[$];
    int          errors = 0;
    int          words_sent = 0;
    logic        quiet = 1'b0;
    logic [31:0] tick_now = '0;

    function automatic void decode_word(input logic op, input logic [7:0] code,
                                        input logic [31:0] ticks);
        t_rec rec;
        logic has_rec;
        has_rec   = 1'b1;
        rec.kind  = KIND_OTHER;
        rec.code  = code;
        rec.value = '0;
        if (op == OP_RESTART) begin
            hb_armed  = 1'b1;
            tod_count = '0;
            has_rec   = 1'b0;
        end else if (code == CODE_TOD_ZERO || code == CODE_TOD_ONE) begin
            tod_shift = {tod_shift[30:0], code == CODE_TOD_ONE};
            if (tod_count < TOD_COUNT_MAX)
                tod_count = tod_count + 6'd1;
            has_rec = 1'b0;
        end else if (code == CODE_HEARTBEAT) begin
            if (hb_armed) begin
                rec.kind = KIND_HB_FIRST;
                hb_armed = 1'b0;
            end else begin
                rec.kind  = KIND_HB;
                rec.value = ticks - hb_prev_ticks;
            end
            hb_prev_ticks = ticks;
        end else if (code == CODE_PPS) begin
            if (tod_count == TOD_BITS) begin
                rec.kind  = KIND_PPS_SEC;
                rec.value = tod_shift;
            end else begin
                rec.kind = KIND_PPS_BARE;
            end
            tod_count = '0;
        end else begin
            rec.value     = ticks - ev_prev_ticks;
            ev_prev_ticks = ticks;
        end
        if (has_rec)
            pending_records.push_back(rec);
    endfunction

    function automatic logic [31:0] next_ticks();
        if ($urandom_range(19) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(1, 4000);
        return tick_now;
    endfunction

    // any code that neither shifts a time bit nor ends a second
    function automatic logic [7:0] plain_code();
        logic [7:0] c;
        if ($urandom_range(2) == 0)
            return CODE_HEARTBEAT;
        c = 8'($urandom_range(255));
        while (c == CODE_TOD_ZERO || c == CODE_TOD_ONE || c == CODE_PPS)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic logic [7:0] noise_code();
        case ($urandom_range(7))
            0: return CODE_TOD_ZERO;
            1: return CODE_TOD_ONE;
            2: return CODE_HEARTBEAT;
            3: return CODE_PPS;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [7:0] code, input logic [31:0] ticks);
        while (!quiet && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ticks, code};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_word(op, code, ticks);
        words_sent++;
    endtask

    // time bits go MSB first; plain events are mixed in when asked
    task automatic send_tod_bits(input logic [31:0] word, input int nbits, input logic mix);
        for (int i = nbits - 1; i >= 0; i--) begin
            if (mix && $urandom_range(9) == 0)
                send_word(OP_EVENT, plain_code(), next_ticks());
            send_word(OP_EVENT, word[i % 32] ? CODE_TOD_ONE : CODE_TOD_ZERO, $urandom);
        end
    endtask

    task automatic test_directed();
        send_word(OP_EVENT, 8'd0, 32'hFFFF_FFFF);          // event straight out of reset
        send_word(OP_EVENT, CODE_HEARTBEAT, 32'd100);      // first heartbeat
        send_word(OP_EVENT, CODE_HEARTBEAT, 32'd50);       // interval wraps
        send_word(OP_EVENT, 8'd255, 32'd0);                // event delta wraps
        send_word(OP_EVENT, 8'd255, 32'hFFFF_FFFF);
        send_word(OP_EVENT, CODE_PPS, 32'd0);              // bare, no bits
        send_word(OP_EVENT, CODE_TOD_ONE, 32'hFFFF_FFFF);
        send_word(OP_EVENT, CODE_TOD_ZERO, 32'd0);
        send_word(OP_EVENT, CODE_PPS, 32'hFFFF_FFFF);      // bare, two bits
        send_word(OP_RESTART, CODE_HEARTBEAT, 32'hFFFF_FFFF);
        send_word(OP_EVENT, CODE_HEARTBEAT, 32'h8000_0000); // first again
        send_word(OP_EVENT, CODE_HEARTBEAT, 32'h7FFF_FFFF);
        send_word(OP_RESTART, 8'd0, 32'd0);
        send_word(OP_EVENT, 8'd1, 32'hAAAA_AAAA);
        send_word(OP_EVENT, 8'd128, 32'h5555_5555);
        send_word(OP_EVENT, CODE_TOD_ONE - 8'd2, 32'd7);
        send_word(OP_EVENT, CODE_PPS + 8'd1, 32'd9);
    endtask

    task automatic test_seconds_word();
        send_tod_bits(32'hFFFF_FFFF, 32, 1'b0);
        send_word(OP_EVENT, CODE_PPS, next_ticks());       // full word
        send_tod_bits(32'h0000_0000, 32, 1'b0);
        send_word(OP_EVENT, CODE_PPS, next_ticks());
        send_tod_bits(32'hA5C3_0F81, 33, 1'b0);
        send_word(OP_EVENT, CODE_PPS, next_ticks());       // one bit too many
        send_tod_bits(32'h1234_5678, 36, 1'b0);
        send_word(OP_EVENT, CODE_PPS, next_ticks());       // count saturated
        send_tod_bits(32'hDEAD_BEEF, 20, 1'b0);
        send_word(OP_RESTART, 8'($urandom_range(255)), $urandom);
        send_tod_bits(32'h8000_0001, 32, 1'b1);
        send_word(OP_EVENT, CODE_PPS, next_ticks());       // restart cleared the count
    endtask

    task automatic test_random_stream();
        int start;
        int frame;
        int mode;
        start = words_sent;
        frame = 0;
        while (words_sent - start < 1700) begin
            quiet = (frame >= 8 && frame < 15);
            mode = $urandom_range(9);
            if (mode <= 6) begin
                send_tod_bits($urandom, 32, 1'b1);
                send_word(OP_EVENT, CODE_PPS, next_ticks());
            end else if (mode == 7) begin
                send_tod_bits($urandom, $urandom_range(28, 36), 1'b1);
                send_word(OP_EVENT, CODE_PPS, next_ticks());
            end else if (mode == 8) begin
                send_tod_bits($urandom, $urandom_range(1, 31), 1'b1);
                send_word(OP_RESTART, 8'($urandom_range(255)), $urandom);
                send_tod_bits($urandom, 32, 1'b1);
                send_word(OP_EVENT, CODE_PPS, next_ticks());
            end else begin
                repeat ($urandom_range(4, 16))
                    send_word($urandom_range(15) == 0, noise_code(),
                              $urandom_range(1) ? $urandom : next_ticks());
            end
            frame++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= 11);

    always @(posedge i_clk) begin : record_check
        t_rec want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record: kind %0d code %0d value %08h",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8]);
                errors++;
            end else begin
                want = pending_records.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("record_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:0] !== want.code) begin
                    $error("event_code_out: expected %0d, got %0d",
                           want.code, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[39:8] !== want.value) begin
                    $error("value: expected %08h, got %08h", want.value, m_axis_tdata[39:8]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_seconds_word();
        test_random_stream();
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_records.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_records.size() != 0) begin
            $error("%0d records never arrived", pending_records.size());
            errors++;
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tled_pkg.sv
hdl/tled_decode.sv
hdl/timing_event_log_decoder_core.sv
bench/testbench.sv
